// ----- design/assert_macros.svh -----
// Assertion helpers shared by the filter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/c3rf_pkg.sv -----
package c3rf_pkg;

    localparam int DEF_MAX_WIDTH      = 2048;
    localparam int DEF_MAX_HEIGHT     = 4096;
    localparam int DEF_COEF_FRAC_BITS = 14;

    localparam int KERN_DIM   = 3;
    localparam int TAPS       = KERN_DIM * KERN_DIM;
    localparam int PIX_W      = 16;
    localparam int COEF_W     = 16;
    localparam int KROW_W     = KERN_DIM * COEF_W;
    localparam int IMG_W_W    = 12;
    localparam int IMG_H_W    = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int Q_DEPTH    = 4;

    localparam int PIX_MAX_NARROW = 255;
    localparam int PIX_MAX_WIDE   = 65535;

    localparam logic [KROW_W-1:0]  RST_K_TOP  = KROW_W'(0);
    localparam logic [KROW_W-1:0]  RST_K_MID  = KROW_W'(16384);
    localparam logic [KROW_W-1:0]  RST_K_BOT  = KROW_W'(0);
    localparam logic [IMG_W_W-1:0] RST_WIDTH  = IMG_W_W'(2048);
    localparam logic [IMG_H_W-1:0] RST_HEIGHT = IMG_H_W'(4096);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_K_TOP,
        REG_K_MID,
        REG_K_BOT,
        REG_WIDTH,
        REG_HEIGHT,
        REG_WIDE
    } t_reg_idx;

    // Row class of an accepted request
    typedef enum logic [2:0] {
        CLS_FIRST,
        CLS_SECOND,
        CLS_BODY,
        CLS_DRAIN,
        CLS_OVER
    } t_cls;

    typedef struct packed {
        logic [KROW_W-1:0]  k_top;
        logic [KROW_W-1:0]  k_mid;
        logic [KROW_W-1:0]  k_bot;
        logic [IMG_W_W-1:0] width;
        logic [IMG_H_W-1:0] height;
        logic               wide;
    } t_cfg;

    typedef logic [TAPS-1:0][PIX_W-1:0] t_taps;

    typedef struct packed {
        t_taps taps;
        logic  last;
    } t_qent;

endpackage

// ----- design/c3rf_if.sv -----
interface c3rf_pix_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [c3rf_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output op, output pixel, input ready);
    modport sink (input valid, input op, input pixel, output ready);
endinterface

interface c3rf_res_if;
    logic                       valid;
    logic                       ready;
    logic [c3rf_pkg::PIX_W-1:0] filtered;
    logic                       clipped;
    logic                       frame_end;

    modport source (output valid, output filtered, output clipped, output frame_end,
                    input ready);
    modport sink (input valid, input filtered, input clipped, input frame_end,
                  output ready);
endinterface

interface c3rf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [c3rf_pkg::CFG_IDX_W-1:0]  index;
    logic [c3rf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/c3rf_front.sv -----
`include "assert_macros.svh"

module c3rf_front #(
    parameter int MAX_WIDTH  = c3rf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = c3rf_pkg::DEF_MAX_HEIGHT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  c3rf_pkg::t_cfg   i_cfg,
    input  logic             i_clear,
    c3rf_pix_if.sink         i_pix,
    output logic             o_q_valid,
    output c3rf_pkg::t_qent  o_q_data,
    input  logic             i_q_ready
);
    import c3rf_pkg::*;

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int YW  = $clog2(MAX_HEIGHT + 2);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int ORW = $clog2(MAX_HEIGHT);

    logic [WW-1:0]    w;
    logic [HW-1:0]    h;

    // input side
    logic [XW-1:0]    r_in_col, n_in_col;
    logic [YW-1:0]    r_in_row, n_in_row;
    logic [XW-1:0]    x_a;
    logic [YW-1:0]    h_y;
    logic [WW-1:0]    x_inc;
    logic [PIX_W-1:0] pix_a;
    logic             ignore_a, edge_a, main_a, accept, fwd, in_ready;
    t_cls             cls_a;

    // line store
    logic [PIX_W-1:0] r_ls_top [MAX_WIDTH];
    logic [PIX_W-1:0] r_ls_mid [MAX_WIDTH];
    logic [PIX_W-1:0] r_top_q, r_mid_q;
    logic             wr_top, wr_mid;

    // window stage
    logic             r_b_valid;
    logic [XW-1:0]    r_b_x;
    t_cls             r_b_cls;
    logic [PIX_W-1:0] r_b_pix;
    logic             r_b_edge, r_b_main, r_b_col1;
    t_taps            r_win, n_win;
    logic [KERN_DIM-1:0][PIX_W-1:0] b_col;
    t_taps            b_taps;
    logic             b_emit, b_last, b_go;
    logic [XW-1:0]    r_out_col, n_out_col;
    logic [ORW-1:0]   r_out_row, n_out_row;
    logic [WW-1:0]    oc_inc;

    always_comb begin
        if (32'(i_cfg.width) < 32'd2) begin
            w = WW'(2);
        end else if (32'(i_cfg.width) > 32'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(i_cfg.width);
        end
        if (32'(i_cfg.height) < 32'd2) begin
            h = HW'(2);
        end else if (32'(i_cfg.height) > 32'(MAX_HEIGHT)) begin
            h = HW'(MAX_HEIGHT);
        end else begin
            h = HW'(i_cfg.height);
        end
    end

    // classify the incoming request
    always_comb begin
        x_a      = (WW'(r_in_col) >= w) ? '0 : r_in_col;
        h_y      = YW'(h);
        pix_a    = i_cfg.wide ? i_pix.pixel : {{(PIX_W - 8){1'b0}}, i_pix.pixel[7:0]};
        ignore_a = (!i_pix.op && (r_in_row >= h_y)) || (i_pix.op && (r_in_row < h_y));
        if (r_in_row == '0) begin
            cls_a = CLS_FIRST;
        end else if (r_in_row == YW'(1)) begin
            cls_a = CLS_SECOND;
        end else if (r_in_row < h_y) begin
            cls_a = CLS_BODY;
        end else if (r_in_row == h_y) begin
            cls_a = CLS_DRAIN;
        end else begin
            cls_a = CLS_OVER;
        end
        edge_a = (r_in_row >= YW'(2)) && (x_a == '0);
        main_a = (cls_a != CLS_OVER) && (r_in_row != '0) && (x_a != '0);
    end

    assign accept      = i_pix.valid && in_ready;
    assign fwd         = accept && !ignore_a;
    assign in_ready    = !r_b_valid || b_go;
    assign i_pix.ready = in_ready;

    always_comb begin
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        x_inc    = WW'(x_a) + WW'(1);
        if (i_clear) begin
            n_in_col = '0;
            n_in_row = '0;
        end else if (fwd) begin
            if (cls_a == CLS_OVER) begin
                n_in_col = '0;
                n_in_row = '0;
            end else if (x_inc >= w) begin
                n_in_col = '0;
                n_in_row = r_in_row + YW'(1);
            end else begin
                n_in_col = x_inc[XW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
        end else begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (in_ready) begin
            r_b_valid <= fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fwd) begin
            r_b_x    <= x_a;
            r_b_cls  <= cls_a;
            r_b_pix  <= pix_a;
            r_b_edge <= edge_a;
            r_b_main <= main_a;
            r_b_col1 <= (x_a == XW'(1));
        end
    end

    // line store writes for the request leaving the window stage
    always_comb begin
        wr_top = 1'b0;
        wr_mid = 1'b0;
        unique case (r_b_cls) inside
            CLS_FIRST: begin
                wr_mid = b_go;
            end
            CLS_SECOND, CLS_BODY: begin
                wr_mid = b_go;
                wr_top = b_go;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_top) begin
            r_ls_top[r_b_x] <= r_mid_q;
        end
        if (fwd) begin
            r_top_q <= r_ls_top[x_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_mid) begin
            r_ls_mid[r_b_x] <= r_b_pix;
        end
        if (fwd) begin
            r_mid_q <= r_ls_mid[x_a];
        end
    end

    // new window column, top to bottom, with row reflection at the frame edges
    always_comb begin
        case (r_b_cls) inside
            CLS_FIRST:  b_col = {r_b_pix, r_b_pix, r_b_pix};
            CLS_SECOND: b_col = {r_b_pix, r_mid_q, r_b_pix};
            CLS_BODY:   b_col = {r_b_pix, r_mid_q, r_top_q};
            default:    b_col = {r_top_q, r_mid_q, r_top_q};
        endcase
    end

    always_comb begin
        for (int r = 0; r < KERN_DIM; r++) begin
            n_win[r * KERN_DIM + 0] = r_win[r * KERN_DIM + 1];
            n_win[r * KERN_DIM + 1] = r_win[r * KERN_DIM + 2];
            n_win[r * KERN_DIM + 2] = b_col[r];
            if (r_b_edge) begin
                // right edge of the previous row: mirror the second-last column
                b_taps[r * KERN_DIM + 0] = r_win[r * KERN_DIM + 1];
                b_taps[r * KERN_DIM + 1] = r_win[r * KERN_DIM + 2];
                b_taps[r * KERN_DIM + 2] = r_win[r * KERN_DIM + 1];
            end else begin
                b_taps[r * KERN_DIM + 0] = r_b_col1 ? b_col[r] : r_win[r * KERN_DIM + 1];
                b_taps[r * KERN_DIM + 1] = r_win[r * KERN_DIM + 2];
                b_taps[r * KERN_DIM + 2] = b_col[r];
            end
        end
    end

    assign b_emit = r_b_edge || r_b_main;
    assign b_last = (HW'(r_out_row) == h - HW'(1)) && (WW'(r_out_col) == w - WW'(1));
    assign b_go   = r_b_valid && (!b_emit || i_q_ready);

    assign o_q_valid     = r_b_valid && b_emit;
    assign o_q_data.taps = b_taps;
    assign o_q_data.last = b_last;

    always_comb begin
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        oc_inc    = WW'(r_out_col) + WW'(1);
        if (i_clear) begin
            n_out_col = '0;
            n_out_row = '0;
        end else if (b_go) begin
            if (b_emit) begin
                if (b_last) begin
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (oc_inc >= w) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + ORW'(1);
                end else begin
                    n_out_col = oc_inc[XW-1:0];
                end
            end
            if (r_b_cls == CLS_OVER) begin
                n_out_col = '0;
                n_out_row = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_col <= '0;
            r_out_row <= '0;
            r_win     <= '0;
        end else begin
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            if (b_go && (r_b_cls != CLS_OVER)) begin
                r_win <= n_win;
            end
        end
    end

    `ASSERT_NEXT(a_fr_over_rewinds, i_clk, i_rst_n, b_go && r_b_cls == CLS_OVER, r_out_col == '0 && r_out_row == '0)

endmodule

// ----- design/c3rf_queue.sv -----
`include "assert_macros.svh"

module c3rf_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    input  c3rf_pkg::t_qent  i_push_data,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output c3rf_pkg::t_qent  o_pop_data,
    input  logic             i_pop_ready
);
    import c3rf_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_qent         r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          push_go, pop_go;

    assign o_push_ready = (r_count != CW'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push_go      = i_push_valid && o_push_ready;
    assign pop_go       = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push_go) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_go) begin
                r_wr <= (r_wr == PW'(Q_DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (pop_go) begin
                r_rd <= (r_rd == PW'(Q_DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (push_go && !pop_go) begin
                r_count <= r_count + CW'(1);
            end else if (pop_go && !push_go) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `ASSERT_NEXT(a_q_fill, i_clk, i_rst_n, push_go && !pop_go, r_count == $past(r_count) + CW'(1))

endmodule

// ----- design/c3rf_back.sv -----
`include "assert_macros.svh"

module c3rf_back #(
    parameter int COEF_FRAC_BITS = c3rf_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  c3rf_pkg::t_cfg   i_cfg,
    input  logic             i_valid,
    input  c3rf_pkg::t_qent  i_data,
    output logic             o_ready,
    c3rf_res_if.source       o_res
);
    import c3rf_pkg::*;

    localparam int PROD_W = PIX_W + 1 + COEF_W;
    localparam int ROW_W  = PROD_W + 2;
    localparam int SUM_W  = PROD_W + 4;
    localparam int Q_W    = SUM_W - COEF_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] BIAS = SUM_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);

    logic [KERN_DIM-1:0][KROW_W-1:0] krows;
    logic signed [COEF_W-1:0]        wt [TAPS];

    logic                     r_p_valid, r_r_valid, r_t_valid, r_o_valid;
    logic                     en_p, en_r, en_t, en_o;
    logic signed [PROD_W-1:0] r_prod [TAPS];
    logic signed [ROW_W-1:0]  r_row [KERN_DIM];
    logic signed [SUM_W-1:0]  r_tot;
    logic                     r_p_last, r_r_last, r_t_last;
    logic signed [SUM_W-1:0]  adj;
    logic signed [Q_W-1:0]    q, maxv;
    logic [PIX_W-1:0]         o_filt;
    logic                     o_clip;
    logic [PIX_W-1:0]         r_o_filt;
    logic                     r_o_clip, r_o_last;

    assign krows = {i_cfg.k_bot, i_cfg.k_mid, i_cfg.k_top};

    for (genvar r = 0; r < KERN_DIM; r++) begin : g_row
        for (genvar c = 0; c < KERN_DIM; c++) begin : g_col
            assign wt[r * KERN_DIM + c] = krows[r][c * COEF_W +: COEF_W];
        end
    end

    assign en_o    = !r_o_valid || o_res.ready;
    assign en_t    = !r_t_valid || en_o;
    assign en_r    = !r_r_valid || en_t;
    assign en_p    = !r_p_valid || en_r;
    assign o_ready = en_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_r_valid <= 1'b0;
            r_t_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (en_p) begin
                r_p_valid <= i_valid;
            end
            if (en_r) begin
                r_r_valid <= r_p_valid;
            end
            if (en_t) begin
                r_t_valid <= r_r_valid;
            end
            if (en_o) begin
                r_o_valid <= r_t_valid;
            end
        end
    end

    // products, row sums, total
    always_ff @(posedge i_clk) begin
        if (en_p) begin
            for (int i = 0; i < TAPS; i++) begin
                r_prod[i] <= $signed({1'b0, i_data.taps[i]}) * wt[i];
            end
            r_p_last <= i_data.last;
        end
        if (en_r) begin
            for (int r = 0; r < KERN_DIM; r++) begin
                r_row[r] <= ROW_W'(r_prod[r * KERN_DIM]) + ROW_W'(r_prod[r * KERN_DIM + 1])
                            + ROW_W'(r_prod[r * KERN_DIM + 2]);
            end
            r_r_last <= r_p_last;
        end
        if (en_t) begin
            r_tot    <= SUM_W'(r_row[0]) + SUM_W'(r_row[1]) + SUM_W'(r_row[2]);
            r_t_last <= r_r_last;
        end
    end

    // truncate toward zero, then saturate to the pixel range
    always_comb begin
        adj  = r_tot[SUM_W-1] ? (r_tot + BIAS) : r_tot;
        q    = $signed(adj[SUM_W-1:COEF_FRAC_BITS]);
        maxv = i_cfg.wide ? Q_W'(PIX_MAX_WIDE) : Q_W'(PIX_MAX_NARROW);
        if (q < 0) begin
            o_filt = '0;
            o_clip = 1'b1;
        end else if (q > maxv) begin
            o_filt = maxv[PIX_W-1:0];
            o_clip = 1'b1;
        end else begin
            o_filt = q[PIX_W-1:0];
            o_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_o_filt <= o_filt;
            r_o_clip <= o_clip;
            r_o_last <= r_t_last;
        end
    end

    assign o_res.valid     = r_o_valid;
    assign o_res.filtered  = r_o_filt;
    assign o_res.clipped   = r_o_clip;
    assign o_res.frame_end = r_o_last;

    `ASSERT_IMPL(a_bk_clip_rail, i_clk, i_rst_n, r_o_valid && r_o_clip, r_o_filt == '0 || r_o_filt == PIX_W'(PIX_MAX_NARROW) || r_o_filt == PIX_W'(PIX_MAX_WIDE))

endmodule

// ----- design/conv3x3_reflect_filter.sv -----
// A result passes the window stage, queue, product, row sum, total and output registers; results
// trail the pixel stream by one row plus one pixel, flushed by width+1 drain requests.
// Throughput: one request per clock, set by the single read and write per cycle on each
// line store row; a full output stalls the input only once the four-entry queue fills.
// Reset (synchronous, active low) restores the register defaults and clears positions, window
// and pipeline; the line store is not cleared and takes no clearing pass.
module conv3x3_reflect_filter #(
    parameter int MAX_WIDTH      = c3rf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = c3rf_pkg::DEF_MAX_HEIGHT,
    parameter int COEF_FRAC_BITS = c3rf_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    c3rf_pix_if.sink    i_pix,
    c3rf_res_if.source  o_res,
    c3rf_cfg_if.sink    i_cfg
);
    import c3rf_pkg::*;

    t_cfg  r_cfg;
    logic  cfg_go, clear;
    logic  q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
    t_qent q_push_data, q_pop_data;

    assign i_cfg.ready = 1'b1;
    assign cfg_go      = i_cfg.valid;
    // a new frame size abandons the frame in flight
    assign clear       = cfg_go && ((i_cfg.index == REG_WIDTH) || (i_cfg.index == REG_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.k_top  <= RST_K_TOP;
            r_cfg.k_mid  <= RST_K_MID;
            r_cfg.k_bot  <= RST_K_BOT;
            r_cfg.width  <= RST_WIDTH;
            r_cfg.height <= RST_HEIGHT;
            r_cfg.wide   <= 1'b0;
        end else if (cfg_go) begin
            unique case (i_cfg.index)
                REG_K_TOP:  r_cfg.k_top  <= i_cfg.data[KROW_W-1:0];
                REG_K_MID:  r_cfg.k_mid  <= i_cfg.data[KROW_W-1:0];
                REG_K_BOT:  r_cfg.k_bot  <= i_cfg.data[KROW_W-1:0];
                REG_WIDTH:  r_cfg.width  <= i_cfg.data[IMG_W_W-1:0];
                REG_HEIGHT: r_cfg.height <= i_cfg.data[IMG_H_W-1:0];
                REG_WIDE:   r_cfg.wide   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    c3rf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_clear   (clear),
        .i_pix     (i_pix),
        .o_q_valid (q_push_valid),
        .o_q_data  (q_push_data),
        .i_q_ready (q_push_ready)
    );

    c3rf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (q_push_valid),
        .i_push_data  (q_push_data),
        .o_push_ready (q_push_ready),
        .o_pop_valid  (q_pop_valid),
        .o_pop_data   (q_pop_data),
        .i_pop_ready  (q_pop_ready)
    );

    c3rf_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_pop_valid),
        .i_data  (q_pop_data),
        .o_ready (q_pop_ready),
        .o_res   (o_res)
    );

endmodule

// ----- sim/conv3x3_reflect_filter_tb.sv -----
`timescale 1ns / 1ps

module conv3x3_reflect_filter_tb;
    import c3rf_pkg::*;

    localparam int MAX_W           = DEF_MAX_WIDTH;
    localparam int MAX_H           = DEF_MAX_HEIGHT;
    localparam int RANDOM_ITEMS    = 900;
    localparam int EXTREME_ITEMS   = 100;
    localparam int SETTLE_CYCLES   = 10;
    localparam int TAIL_CYCLES     = 20;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int REPORT_LIMIT    = 10;
    localparam int SCRIPT_LEN      = 28;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(int'(REG_WIDE) + 1);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(int'(REG_WIDE) + 2);

    typedef enum logic {OP_PIXEL, OP_DRAIN} t_op;
    typedef enum logic {ROW_REG, ROW_ITEM} t_row_kind;
    typedef enum logic [1:0] {CHK_NONE, CHK_TYPED, CHK_MODEL} t_chk;

    typedef struct packed {
        logic [PIX_W-1:0] filtered;
        logic             clipped;
        logic             frame_end;
    } t_pix_result;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_op                   op;
        logic [PIX_W-1:0]      pix;
        t_chk                  chk;
        t_pix_result           typed;
    } t_script_row;

    localparam t_pix_result NO_RESULT = '0;

    // Three 2x2 frames: reflection and byte masking, clipping high, clipping low in wide mode
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        '{ROW_REG,  REG_WIDTH,  48'd2,      OP_PIXEL, 16'h0000, CHK_NONE,  NO_RESULT},
        '{ROW_REG,  REG_HEIGHT, 48'd2,      OP_PIXEL, 16'h0000, CHK_NONE,  NO_RESULT},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_DRAIN, 16'h0000, CHK_NONE,  NO_RESULT},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_PIXEL, 16'h00FF, CHK_NONE,  NO_RESULT},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_PIXEL, 16'h1234, CHK_NONE,  NO_RESULT},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_PIXEL, 16'h0012, CHK_NONE,  NO_RESULT},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_PIXEL, 16'hFF34, CHK_MODEL, NO_RESULT},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_PIXEL, 16'hFFFF, CHK_NONE,  NO_RESULT},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_DRAIN, 16'h0000, CHK_MODEL, NO_RESULT},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_DRAIN, 16'h0000, CHK_MODEL, NO_RESULT},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_DRAIN, 16'h0000, CHK_MODEL, NO_RESULT},
        '{ROW_REG,  REG_K_MID,  48'h7FFF,   OP_PIXEL, 16'h0000, CHK_NONE,  NO_RESULT},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_PIXEL, 16'h00FF, CHK_NONE,  NO_RESULT},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_PIXEL, 16'h00FF, CHK_NONE,  NO_RESULT},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_PIXEL, 16'h00FF, CHK_NONE,  NO_RESULT},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_PIXEL, 16'h00FF, CHK_TYPED, '{16'd255, 1'b1, 1'b0}},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_DRAIN, 16'h0000, CHK_TYPED, '{16'd255, 1'b1, 1'b0}},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_DRAIN, 16'h0000, CHK_TYPED, '{16'd255, 1'b1, 1'b0}},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_DRAIN, 16'h0000, CHK_TYPED, '{16'd255, 1'b1, 1'b1}},
        '{ROW_REG,  REG_K_MID,  48'h8000,   OP_PIXEL, 16'h0000, CHK_NONE,  NO_RESULT},
        '{ROW_REG,  REG_WIDE,   48'd1,      OP_PIXEL, 16'h0000, CHK_NONE,  NO_RESULT},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_PIXEL, 16'hFFFF, CHK_NONE,  NO_RESULT},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_PIXEL, 16'hFFFF, CHK_NONE,  NO_RESULT},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_PIXEL, 16'hFFFF, CHK_NONE,  NO_RESULT},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_PIXEL, 16'hFFFF, CHK_TYPED, '{16'd0, 1'b1, 1'b0}},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_DRAIN, 16'h0000, CHK_TYPED, '{16'd0, 1'b1, 1'b0}},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_DRAIN, 16'h0000, CHK_TYPED, '{16'd0, 1'b1, 1'b0}},
        '{ROW_ITEM, REG_K_TOP,  48'd0,      OP_DRAIN, 16'h0000, CHK_TYPED, '{16'd0, 1'b1, 1'b1}}
    };

    logic i_clk;
    logic i_rst_n;

    c3rf_pix_if pix_bus ();
    c3rf_res_if res_bus ();
    c3rf_cfg_if cfg_bus ();

    conv3x3_reflect_filter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    // Filter state mirrored at request level
    logic [KROW_W-1:0]  kern_rows [3] = '{RST_K_TOP, RST_K_MID, RST_K_BOT};
    logic [IMG_W_W-1:0] width_reg  = RST_WIDTH;
    logic [IMG_H_W-1:0] height_reg = RST_HEIGHT;
    logic               wide_reg   = 1'b0;
    logic [PIX_W-1:0]   line_mem [2 * MAX_W];
    int unsigned        win [TAPS] = '{default: 0};
    int unsigned        taps [TAPS];
    int unsigned        in_col = 0, in_row = 0, out_col = 0, out_row = 0;

    t_pix_result expected_q [$];
    int unsigned fail_count = 0;
    int unsigned items_done = 0;
    bit          pix_held = 1'b0;
    bit          send_calm = 1'b0;
    bit          take_calm = 1'b0;
    bit          must_reframe = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_width();
        return (width_reg < 2) ? 2 : ((width_reg > MAX_W) ? MAX_W : 32'(width_reg));
    endfunction

    function automatic int unsigned eff_height();
        return (height_reg < 2) ? 2 : ((height_reg > MAX_H) ? MAX_H : 32'(height_reg));
    endfunction

    function automatic void clear_positions();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_K_TOP: kern_rows[0] = val;
            REG_K_MID: kern_rows[1] = val;
            REG_K_BOT: kern_rows[2] = val;
            REG_WIDTH: begin
                width_reg = val[IMG_W_W-1:0];
                clear_positions();
            end
            REG_HEIGHT: begin
                height_reg = val[IMG_H_W-1:0];
                clear_positions();
            end
            REG_WIDE: wide_reg = val[0];
            default: ;
        endcase
    endfunction

    // Weighted sum of taps, truncated toward zero, then saturated; advances the output position
    function automatic t_pix_result window_sum(input int unsigned w, input int unsigned h);
        longint      acc, q, top;
        logic [COEF_W-1:0] coef;
        t_pix_result r;
        acc = 0;
        for (int i = 0; i < TAPS; i++) begin
            coef = kern_rows[i / 3][COEF_W * (i % 3) +: COEF_W];
            acc += longint'(taps[i]) * longint'($signed(coef));
        end
        q = acc / (longint'(1) << DEF_COEF_FRAC_BITS);
        top = wide_reg ? longint'(PIX_MAX_WIDE) : longint'(PIX_MAX_NARROW);
        if (q < 0) begin
            r.filtered = '0;
            r.clipped = 1'b1;
        end else if (q > top) begin
            r.filtered = top[PIX_W-1:0];
            r.clipped = 1'b1;
        end else begin
            r.filtered = q[PIX_W-1:0];
            r.clipped = 1'b0;
        end
        r.frame_end = (out_row == h - 1 && out_col == w - 1);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        if (r.frame_end) begin
            out_col = 0;
            out_row = 0;
        end
        return r;
    endfunction

    function automatic bit convolve_step(input t_op op, input logic [PIX_W-1:0] pix_in,
                                         output t_pix_result res);
        int unsigned w, h, x, y, pix;
        int unsigned col [3];
        bit made;
        w = eff_width();
        h = eff_height();
        pix = wide_reg ? 32'(pix_in) : 32'(pix_in[7:0]);
        made = 1'b0;
        res = NO_RESULT;
        if (op == OP_PIXEL && in_row >= h) return 1'b0;
        if (op == OP_DRAIN && in_row < h) return 1'b0;
        if (in_col >= w) in_col = 0;
        y = in_row;
        x = in_col;

        // right edge of the previous centre row, taken before the window shifts
        if (y >= 2 && x == 0) begin
            for (int r = 0; r < 3; r++) begin
                taps[r * 3]     = win[r * 3 + 1];
                taps[r * 3 + 1] = win[r * 3 + 2];
                taps[r * 3 + 2] = win[r * 3 + 1];
            end
            res = window_sum(w, h);
            made = 1'b1;
        end
        if (y > h) begin
            clear_positions();
            return made;
        end

        if (y == 0) begin
            col[0] = pix;
            col[1] = pix;
            col[2] = pix;
            line_mem[MAX_W + x] = PIX_W'(pix);
        end else if (y < h) begin
            col[0] = (y == 1) ? pix : 32'(line_mem[x]);
            col[1] = 32'(line_mem[MAX_W + x]);
            col[2] = pix;
            line_mem[x] = line_mem[MAX_W + x];
            line_mem[MAX_W + x] = PIX_W'(pix);
        end else begin
            // bottom border reflects the row above
            col[0] = 32'(line_mem[x]);
            col[1] = 32'(line_mem[MAX_W + x]);
            col[2] = 32'(line_mem[x]);
        end
        for (int r = 0; r < 3; r++) begin
            win[r * 3]     = win[r * 3 + 1];
            win[r * 3 + 1] = win[r * 3 + 2];
            win[r * 3 + 2] = col[r];
        end

        if (y >= 1 && x >= 1) begin
            for (int r = 0; r < 3; r++) begin
                taps[r * 3]     = (x == 1) ? win[r * 3 + 2] : win[r * 3];
                taps[r * 3 + 1] = win[r * 3 + 1];
                taps[r * 3 + 2] = win[r * 3 + 2];
            end
            res = window_sum(w, h);
            made = 1'b1;
        end

        in_col = x + 1;
        if (in_col >= w) begin
            in_col = 0;
            in_row = y + 1;
        end
        return made;
    endfunction

    function automatic int unsigned draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return 16'($urandom);
            default: return wide_reg ? 16'($urandom) : {8'h00, 8'($urandom)};
        endcase
    endfunction

    function automatic logic [KROW_W-1:0] random_krow();
        logic [KROW_W-1:0] row;
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 6))
                0: row[COEF_W * i +: COEF_W] = 16'($urandom);
                1: row[COEF_W * i +: COEF_W] = 16'h7FFF;
                2: row[COEF_W * i +: COEF_W] = 16'h8000;
                3: row[COEF_W * i +: COEF_W] = 16'h0000;
                4: row[COEF_W * i +: COEF_W] = 16'h4000;
                default: row[COEF_W * i +: COEF_W] = 16'($urandom_range(0, 8192) - 4096);
            endcase
        end
        return row;
    endfunction

    // Hold the sender until every expected result is back and the pipeline has emptied
    task automatic settle();
        if (pix_held) begin
            pix_bus.valid <= 1'b0;
            pix_held = 1'b0;
        end
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        settle();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        apply_reg(idx, val);
    endtask

    // valid stays high after a request when the next one follows without a gap
    task automatic send_item(input t_op op, input logic [PIX_W-1:0] pix, input t_chk chk,
                             input t_pix_result typed);
        t_pix_result predicted;
        bit          produced;
        int unsigned gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            if (pix_held) begin
                pix_bus.valid <= 1'b0;
                pix_held = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.op    <= op;
        pix_bus.pixel <= pix;
        pix_held = 1'b1;
        do @(posedge i_clk); while (!pix_bus.ready);
        produced = convolve_step(op, pix, predicted);
        if (chk == CHK_MODEL && produced) expected_q = {expected_q, predicted};
        else if (chk == CHK_TYPED) expected_q = {expected_q, typed};
    endtask

    task automatic run_frame(input bit noisy, output bit broken);
        int unsigned w, h, pixels, total, cut;
        w = eff_width();
        h = eff_height();
        pixels = w * h;
        total = pixels + w + 1;
        cut = total;
        if (noisy && $urandom_range(0, 9) == 0) cut = $urandom_range(1, total - 1);
        broken = (cut < total);
        for (int unsigned k = 0; k < cut; k++) begin
            if (noisy && $urandom_range(0, 49) == 0) begin
                settle();
                case ($urandom_range(0, 4))
                    0: write_reg(REG_K_TOP, random_krow());
                    1: write_reg(REG_K_MID, random_krow());
                    2: write_reg(REG_K_BOT, random_krow());
                    3: write_reg(REG_WIDE, 48'($urandom_range(0, 1)));
                    default: ;
                endcase
            end
            if (k < pixels) begin
                // a drain request mid-frame must be dropped
                if (noisy && $urandom_range(0, 15) == 0)
                    send_item(OP_DRAIN, random_pixel(), CHK_MODEL, NO_RESULT);
                send_item(OP_PIXEL, random_pixel(), CHK_MODEL, NO_RESULT);
            end else begin
                if (k == pixels && noisy && $urandom_range(0, 3) == 0)
                    send_item(OP_PIXEL, random_pixel(), CHK_MODEL, NO_RESULT);
                send_item(OP_DRAIN, random_pixel(), CHK_MODEL, NO_RESULT);
            end
            items_done++;
        end
    endtask

    // Feed the start of a frame only; the next size write abandons it
    task automatic send_pixels(input int unsigned count);
        for (int unsigned k = 0; k < count; k++) begin
            send_item(OP_PIXEL, random_pixel(), CHK_MODEL, NO_RESULT);
            items_done++;
        end
    endtask

    task automatic run_phase(input bit all_regs);
        int unsigned frames;
        bit broken;
        if (all_regs || $urandom_range(0, 1)) write_reg(REG_K_TOP, random_krow());
        if (all_regs || $urandom_range(0, 1)) write_reg(REG_K_MID, random_krow());
        if (all_regs || $urandom_range(0, 1)) write_reg(REG_K_BOT, random_krow());
        if (all_regs || $urandom_range(0, 3) == 0) write_reg(REG_WIDE, 48'($urandom_range(0, 1)));
        if (all_regs) begin
            write_reg(REG_SPARE_A, 48'({$urandom, $urandom}));
            write_reg(REG_SPARE_B, 48'({$urandom, $urandom}));
        end
        if (all_regs || must_reframe || $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 9))
                0: write_reg(REG_WIDTH, 48'($urandom_range(0, 1)));
                1: write_reg(REG_WIDTH, 48'($urandom_range(10, 40)));
                default: write_reg(REG_WIDTH, 48'($urandom_range(2, 9)));
            endcase
            case ($urandom_range(0, 9))
                0: write_reg(REG_HEIGHT, 48'($urandom_range(0, 1)));
                default: write_reg(REG_HEIGHT, 48'($urandom_range(2, 6)));
            endcase
            must_reframe = 1'b0;
        end
        send_calm = ($urandom_range(0, 3) == 0);
        take_calm = ($urandom_range(0, 3) == 0);
        frames = $urandom_range(1, 3);
        repeat (frames) begin
            run_frame(1'b1, broken);
            if (broken) begin
                must_reframe = 1'b1;
                break;
            end
        end
    endtask

    initial begin
        t_pix_result want, got;
        int unsigned gap;
        forever begin
            gap = draw_gap(take_calm);
            if (gap > 0) begin
                res_bus.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!res_bus.valid);
            got.filtered  = res_bus.filtered;
            got.clipped   = res_bus.clipped;
            got.frame_end = res_bus.frame_end;
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected result: filtered=%h clipped=%b frame_end=%b",
                             got.filtered, got.clipped, got.frame_end);
            end else begin
                want = expected_q.pop_front();
                if (got.filtered !== want.filtered || got.clipped !== want.clipped ||
                    got.frame_end !== want.frame_end) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("mismatch at %0t: expected %h/%b/%b got %h/%b/%b", $realtime,
                                 want.filtered, want.clipped, want.frame_end,
                                 got.filtered, got.clipped, got.frame_end);
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        pix_bus.valid <= 1'b0;
        pix_bus.op    <= OP_PIXEL;
        pix_bus.pixel <= '0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= '0;
        cfg_bus.data  <= '0;
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (SCRIPT[i]) begin
            if (SCRIPT[i].kind == ROW_REG)
                write_reg(SCRIPT[i].idx, SCRIPT[i].data);
            else
                send_item(SCRIPT[i].op, SCRIPT[i].pix, SCRIPT[i].chk, SCRIPT[i].typed);
        end

        run_phase(1'b1);
        while (items_done < RANDOM_ITEMS) run_phase(1'b0);

        // clamped extremes: over-wide rows on the shortest frame, then the tallest frame,
        // each fed for a short stretch and then abandoned
        write_reg(REG_WIDTH, 48'hFFF);
        write_reg(REG_HEIGHT, 48'd1);
        send_pixels(EXTREME_ITEMS);
        write_reg(REG_WIDTH, 48'd2);
        write_reg(REG_HEIGHT, 48'h1FFF);
        send_pixels(EXTREME_ITEMS);

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/c3rf_pkg.sv
design/c3rf_if.sv
design/c3rf_front.sv
design/c3rf_queue.sv
design/c3rf_back.sv
design/conv3x3_reflect_filter.sv
sim/conv3x3_reflect_filter_tb.sv
